/* hdl/iem_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package iem_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int BOUND_BITS  = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] FN_APP_FREE  = 3'd0;
  localparam logic [2:0] FN_APP_TAKEN = 3'd1;
  localparam logic [2:0] FN_EXTRACT   = 3'd2;
  localparam logic [2:0] FN_RD_FREE   = 3'd3;
  localparam logic [2:0] FN_RD_TAKEN  = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FREE_FULL  = 2'd1;
  localparam logic [1:0] ST_TAKEN_FULL = 2'd2;

  typedef struct packed {
    logic [BOUND_BITS-1:0] e;
    logic [BOUND_BITS-1:0] s;
  } ent_t;

  typedef struct packed {
    logic                  found;
    logic [1:0]            status;
    logic                  ev;
    logic [BOUND_BITS-1:0] elo;
    logic [BOUND_BITS-1:0] ehi;
    logic [CNT_W-1:0]      ftot;
    logic [CNT_W-1:0]      ttot;
  } res_t;

  function automatic logic pair_less(input ent_t a, input ent_t b);
    pair_less = (a.s < b.s) || ((a.s == b.s) && (a.e < b.e));
  endfunction

endpackage
`default_nettype wire

/* hdl/iem_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module iem_ram
  import iem_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire ent_t          wdata,
  input  wire logic [AW-1:0] raddr,
  output      ent_t          rdata
);

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/iem_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module iem_ctrl
  import iem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_valid,
  output      logic                  req_ready,
  input  wire logic [2:0]            req_func,
  input  wire logic [BOUND_BITS-1:0] req_lo,
  input  wire logic [BOUND_BITS-1:0] req_hi,
  input  wire logic [IDX_W-1:0]      req_slot,
  output      logic                  res_valid,
  input  wire logic                  res_ready,
  output      res_t                  res,
  output      logic                  f_we,
  output      logic [IDX_W-1:0]      f_waddr,
  output      ent_t                  f_wdata,
  output      logic [IDX_W-1:0]      f_raddr,
  input  wire ent_t                  f_rdata,
  output      logic                  t_we,
  output      logic [IDX_W:0]        t_waddr,
  output      ent_t                  t_wdata,
  output      logic [IDX_W:0]        t_raddr,
  input  wire ent_t                  t_rdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_FSCAN = 4'd2;
  localparam logic [3:0] S_SORT = 4'd3;
  localparam logic [3:0] S_MEND = 4'd4;
  localparam logic [3:0] S_DEC = 4'd5;
  localparam logic [3:0] S_FDEL = 4'd6;
  localparam logic [3:0] S_FINS = 4'd7;
  localparam logic [3:0] S_FWR1 = 4'd8;
  localparam logic [3:0] S_FWR2 = 4'd9;
  localparam logic [3:0] S_RDF = 4'd10;
  localparam logic [3:0] S_RDT = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_ENTRIES);

  logic [3:0] st_r, st_nxt;
  logic [2:0] func_r;
  logic [BOUND_BITS-1:0] lo_r, hi_r;
  logic [IDX_W-1:0] slot_r;
  logic [CNT_W-1:0] fc_r, fc_nxt, tc_r, tc_nxt;
  logic bank_r, bank_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, idd_r, idd_nxt;
  logic vld_r, vld_nxt;
  logic hit_r, hit_nxt;
  logic [IDX_W-1:0] hidx_r, hidx_nxt;
  ent_t hent_r, hent_nxt;
  logic have_prev_r, have_prev_nxt, best_ok_r, best_ok_nxt, mg_r, mg_nxt;
  ent_t prev_r, prev_nxt, best_r, best_nxt, cur_r, cur_nxt;
  logic [CNT_W-1:0] pi_r, pi_nxt, bi_r, bi_nxt, pass_r, pass_nxt, mc_r, mc_nxt;
  res_t res_r, res_nxt;

  ent_t req_ent, el;
  logic split, gt, better;
  logic [CNT_W-1:0] hidx1;

  assign req_ent   = '{s: lo_r, e: hi_r};
  assign split     = hit_r && (hent_r.s != lo_r) && (hent_r.e != hi_r);
  assign hidx1     = CNT_W'(hidx_r) + CNT_W'(1);
  assign req_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_DONE);
  assign res       = '{found: res_r.found, status: res_r.status, ev: res_r.ev,
                       elo: res_r.elo, ehi: res_r.ehi, ftot: fc_r, ttot: tc_r};
  assign f_raddr   = (st_r == S_DISP) ? slot_r : idx_r[IDX_W-1:0];
  assign t_raddr   = {bank_r, (st_r == S_DISP) ? slot_r : idx_r[IDX_W-1:0]};

  // element under compare in the sort pass: the request sits past the table end
  assign el     = (idd_r == tc_r) ? req_ent : t_rdata;
  assign gt     = !have_prev_r || pair_less(prev_r, el) ||
                  ((prev_r == el) && (pi_r < idd_r));
  assign better = !best_ok_r || pair_less(el, best_r);

  always_comb begin
    st_nxt = st_r; fc_nxt = fc_r; tc_nxt = tc_r; bank_nxt = bank_r;
    idx_nxt = idx_r; idd_nxt = idd_r; vld_nxt = 1'b0;
    hit_nxt = hit_r; hidx_nxt = hidx_r; hent_nxt = hent_r;
    have_prev_nxt = have_prev_r; best_ok_nxt = best_ok_r; mg_nxt = mg_r;
    prev_nxt = prev_r; best_nxt = best_r; cur_nxt = cur_r;
    pi_nxt = pi_r; bi_nxt = bi_r; pass_nxt = pass_r; mc_nxt = mc_r;
    res_nxt = res_r;
    f_we = 1'b0; f_waddr = '0; f_wdata = req_ent;
    t_we = 1'b0; t_waddr = '0; t_wdata = cur_r;
    unique case (st_r)
      S_IDLE: begin
        if (req_valid) st_nxt = S_DISP;
      end
      S_DISP: begin
        res_nxt = '0;
        st_nxt  = S_DONE;
        idx_nxt = '0;
        hit_nxt = 1'b0;
        unique case (func_r)
          FN_APP_FREE: begin
            if (fc_r >= MAXC) begin
              res_nxt.status = ST_FREE_FULL;
            end else begin
              f_we = 1'b1; f_waddr = fc_r[IDX_W-1:0];
              fc_nxt = fc_r + CNT_W'(1);
            end
          end
          FN_APP_TAKEN: begin
            if (tc_r >= MAXC) begin
              res_nxt.status = ST_TAKEN_FULL;
            end else begin
              t_we = 1'b1; t_waddr = {bank_r, tc_r[IDX_W-1:0]}; t_wdata = req_ent;
              tc_nxt = tc_r + CNT_W'(1);
            end
          end
          FN_EXTRACT: begin
            if (lo_r <= hi_r) st_nxt = S_FSCAN;
          end
          FN_RD_FREE: begin
            if (CNT_W'(slot_r) < fc_r) st_nxt = S_RDF;
          end
          FN_RD_TAKEN: begin
            if (CNT_W'(slot_r) < tc_r) st_nxt = S_RDT;
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_FSCAN: begin
        if (vld_r && (f_rdata.s <= lo_r) && (hi_r <= f_rdata.e)) begin
          hit_nxt = 1'b1; hidx_nxt = idd_r[IDX_W-1:0]; hent_nxt = f_rdata;
        end
        if ((vld_r && (f_rdata.s <= lo_r) && (hi_r <= f_rdata.e)) ||
            (!vld_r && idx_r >= fc_r)) begin
          st_nxt = S_SORT; idx_nxt = '0; have_prev_nxt = 1'b0;
          best_ok_nxt = 1'b0; pass_nxt = '0; mg_nxt = 1'b0; mc_nxt = '0;
        end else if (idx_r < fc_r) begin
          vld_nxt = 1'b1; idd_nxt = idx_r; idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_SORT: begin
        if (vld_r && gt && better) begin
          best_nxt = el; bi_nxt = idd_r; best_ok_nxt = 1'b1;
        end
        if (!vld_r && idx_r > tc_r) begin
          // one pass done: best holds the next element in sorted order
          if (!mg_r) begin
            cur_nxt = best_r; mg_nxt = 1'b1;
          end else if (cur_r.e >= best_r.s) begin
            if (best_r.e > cur_r.e) cur_nxt.e = best_r.e;
          end else begin
            t_we = (mc_r < MAXC); t_waddr = {~bank_r, mc_r[IDX_W-1:0]};
            mc_nxt = mc_r + CNT_W'(1);
            cur_nxt = best_r;
          end
          prev_nxt = best_r; pi_nxt = bi_r; have_prev_nxt = 1'b1;
          best_ok_nxt = 1'b0; idx_nxt = '0;
          pass_nxt = pass_r + CNT_W'(1);
          if (pass_r == tc_r) st_nxt = S_MEND;
        end else if (idx_r <= tc_r) begin
          vld_nxt = 1'b1; idd_nxt = idx_r; idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_MEND: begin
        t_we = (mc_r < MAXC); t_waddr = {~bank_r, mc_r[IDX_W-1:0]};
        mc_nxt = mc_r + CNT_W'(1);
        st_nxt = S_DEC;
      end
      S_DEC: begin
        res_nxt.found = hit_r;
        st_nxt = S_DONE;
        if (split && fc_r >= MAXC) begin
          res_nxt.status = ST_FREE_FULL;
        end else if (mc_r > MAXC) begin
          res_nxt.status = ST_TAKEN_FULL;
        end else begin
          bank_nxt = ~bank_r; tc_nxt = mc_r;
          if (hit_r) begin
            f_waddr = hidx_r;
            if (hent_r.s == lo_r && hent_r.e == hi_r) begin
              st_nxt = S_FDEL; idx_nxt = hidx1;
            end else if (hent_r.s == lo_r) begin
              f_we = 1'b1; f_wdata = '{s: hi_r + BOUND_BITS'(1), e: hent_r.e};
            end else if (hent_r.e == hi_r) begin
              f_we = 1'b1; f_wdata = '{s: hent_r.s, e: lo_r - BOUND_BITS'(1)};
            end else begin
              st_nxt = S_FINS; idx_nxt = fc_r - CNT_W'(1);
            end
          end
        end
      end
      S_FDEL: begin
        if (vld_r) begin
          f_we = 1'b1; f_waddr = idd_r[IDX_W-1:0] - IDX_W'(1); f_wdata = f_rdata;
        end
        if (!vld_r && idx_r >= fc_r) begin
          fc_nxt = fc_r - CNT_W'(1); st_nxt = S_DONE;
        end else if (idx_r < fc_r) begin
          vld_nxt = 1'b1; idd_nxt = idx_r; idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_FINS: begin
        if (vld_r) begin
          f_we = 1'b1; f_waddr = idd_r[IDX_W-1:0] + IDX_W'(1); f_wdata = f_rdata;
        end
        if (!vld_r && idx_r < hidx1) begin
          st_nxt = S_FWR1;
        end else if (idx_r >= hidx1) begin
          vld_nxt = 1'b1; idd_nxt = idx_r; idx_nxt = idx_r - CNT_W'(1);
        end
      end
      S_FWR1: begin
        f_we = 1'b1; f_waddr = hidx_r;
        f_wdata = '{s: hent_r.s, e: lo_r - BOUND_BITS'(1)};
        st_nxt = S_FWR2;
      end
      S_FWR2: begin
        f_we = 1'b1; f_waddr = hidx1[IDX_W-1:0];
        f_wdata = '{s: hi_r + BOUND_BITS'(1), e: hent_r.e};
        fc_nxt = fc_r + CNT_W'(1);
        st_nxt = S_DONE;
      end
      S_RDF: begin
        res_nxt.ev = 1'b1; res_nxt.elo = f_rdata.s; res_nxt.ehi = f_rdata.e;
        st_nxt = S_DONE;
      end
      S_RDT: begin
        res_nxt.ev = 1'b1; res_nxt.elo = t_rdata.s; res_nxt.ehi = t_rdata.e;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fc_r <= '0; tc_r <= '0; bank_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fc_r <= fc_nxt; tc_r <= tc_nxt; bank_r <= bank_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && req_valid) begin
      func_r <= req_func; lo_r <= req_lo; hi_r <= req_hi; slot_r <= req_slot;
    end
    idx_r <= idx_nxt; idd_r <= idd_nxt; hit_r <= hit_nxt; hidx_r <= hidx_nxt;
    hent_r <= hent_nxt; have_prev_r <= have_prev_nxt; best_ok_r <= best_ok_nxt;
    mg_r <= mg_nxt; prev_r <= prev_nxt; best_r <= best_nxt; cur_r <= cur_nxt;
    pi_r <= pi_nxt; bi_r <= bi_nxt; pass_r <= pass_nxt; mc_r <= mc_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

/* hdl/interval_extract_and_merge_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata (lsb up)                              | tuser (lsb up)
// in_     | in  | lo_bound 16, hi_bound 16, slot 4, pad 4      | func 3
// out_    | out | entry_lo 16, entry_hi 16, free_total 5,      | found 1, status 2,
//         |     | taken_total 5, pad 6                         | entry_valid 1
// an extract runs a scan of the free table, then sort passes over the taken memory, then
//   a shift of the free table when an entry is removed or split; the passes are a
//   selection sort over the single read port of the taken memory
// reset: rst_n synchronous active low clears both counts; table contents are kept
// stalls: one item in work at a time; a held result does not block the next transfer
module interval_extract_and_merge_top
  import iem_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // lo_bound, hi_bound, slot
  input  wire logic [2:0]  in_tuser,   // func
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // entry_lo, entry_hi, free_total, taken_total
  output      logic [3:0]  out_tuser   // found, status, entry_valid
);

  res_t res, out_r;
  logic res_valid, res_ready, out_tvalid_r;
  logic f_we, t_we;
  logic [IDX_W-1:0] f_waddr, f_raddr;
  logic [IDX_W:0] t_waddr, t_raddr;
  ent_t f_wdata, f_rdata, t_wdata, t_rdata;

  // output register frees the controller as soon as a result is parked
  assign res_ready = !out_tvalid_r || out_tready;

  iem_ctrl u_ctrl (
    .clk, .rst_n,
    .req_valid(in_tvalid), .req_ready(in_tready),
    .req_func(in_tuser), .req_lo(in_tdata[15:0]), .req_hi(in_tdata[31:16]),
    .req_slot(in_tdata[35:32]),
    .res_valid, .res_ready, .res,
    .f_we, .f_waddr, .f_wdata, .f_raddr, .f_rdata,
    .t_we, .t_waddr, .t_wdata, .t_raddr, .t_rdata
  );

  // free table, list order
  iem_ram #(.DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_free_ram (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // taken table, two banks: the merged table is built in the idle bank
  iem_ram #(.DEPTH(2 * MAX_ENTRIES), .AW(IDX_W + 1)) u_taken_ram (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_r.ttot, out_r.ftot, out_r.ehi, out_r.elo};
  assign out_tuser  = {out_r.ev, out_r.status, out_r.found};

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");
  a_totals_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:32] <= 5'd16) && (out_tdata[41:37] <= 5'd16))
    else $error("table total beyond capacity");
  a_found_not_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[3])
    else $error("found and entry_valid together");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] != 2'd3)
    else $error("bad status code");
`endif

endmodule
`default_nettype wire
